/* rtl/hgt_pkg.sv */
package hgt_pkg;

  localparam int PIECE_KINDS = 12;
  localparam int SQUARES     = 64;
  localparam int TABLE_DEPTH = PIECE_KINDS * SQUARES;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);

  localparam int OP_W     = 2;
  localparam int PIECE_W  = 4;
  localparam int SQ_W     = 6;
  localparam int DEPTH_W  = 8;
  localparam int CAP_W    = 16;
  localparam int SCALE_W  = 8;
  localparam int SCORE_W  = 17;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = SCORE_W + 1;
  localparam int MUL_B_W = CAP_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int GRAVITY_SHIFT = 15;
  localparam int Q_W           = 18;
  localparam int SUM_W         = 20;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 16'd1200;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd16;

  localparam logic [CFG_IDX_W-1:0] REG_BONUS_CAP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BONUS_SCALE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_REWARD   = 2'd0,
    OP_PENALIZE = 2'd1,
    OP_READ     = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_BONUS,
    ST_MUL3,
    ST_WB,
    ST_EMIT
  } state_t;

endpackage

/* rtl/history_gravity_table.sv */
// an accepted word steps through ST_MUL1, ST_MUL2, ST_BONUS, ST_MUL3 and ST_WB to ST_EMIT
// no new word until ST_IDLE is back; the single shared multiplier is used for
//   three passes per word (depth squared, times scale, entry times bonus)
// clear opcode: sweep of all 768 score memory entries, one entry a cycle, then the result
// reset: synchronous active-low; afterwards the same full sweep runs before in_stall drops
module history_gravity_table (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [hgt_pkg::OP_W-1:0]               in_opcode,
  input  logic [hgt_pkg::PIECE_W-1:0]            in_moved_piece,
  input  logic [hgt_pkg::SQ_W-1:0]               in_from_square,
  input  logic [hgt_pkg::SQ_W-1:0]               in_to_square,
  input  logic [hgt_pkg::DEPTH_W-1:0]            in_depth,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [hgt_pkg::SCORE_W-1:0]     out_score,
  output logic                                   out_skipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [hgt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [hgt_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import hgt_pkg::*;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]         clr_cnt_r;
  logic                      clr_emit_r;
  logic                      clr_last;

  op_t                       op_r;
  logic [SQ_W-1:0]           from_r;
  logic [SQ_W-1:0]           to_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic                      ok_r;
  logic [SLOT_W-1:0]         slot_r;
  logic signed [SCORE_W-1:0] entry_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [CAP_W-1:0]          bonus_r;
  logic signed [SCORE_W-1:0] pend_score_r;
  logic                      pend_skip_r;
  logic [SQ_W-1:0]           best_from_r;
  logic [SQ_W-1:0]           best_to_r;
  logic [CAP_W-1:0]          cap_r;
  logic [SCALE_W-1:0]        scale_r;
  logic                      out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic                      out_skipped_r;

  logic signed [SCORE_W-1:0] mem [TABLE_DEPTH];

  logic                      in_accept;
  logic                      in_ok;
  logic [SLOT_W-1:0]         in_slot;
  logic                      out_free;
  logic                      mem_we;
  logic [SLOT_W-1:0]         mem_addr;
  logic signed [SCORE_W-1:0] mem_wdata;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic                      wb_skip;
  logic                      wb_upd;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [Q_W-1:0]     q;
  logic signed [Q_W-1:0]     bsig;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SCORE_W-1:0] sat;
  logic signed [SCORE_W-1:0] wb_score;

  // ---------------------------------------------------------------- input side
  assign in_accept = in_valid && !in_stall;
  assign in_ok     = (PIECE_W'(in_moved_piece) < PIECE_W'(PIECE_KINDS)) &&
                     ((SQ_W+1)'(in_to_square) < (SQ_W+1)'(SQUARES));
  assign in_slot   = in_ok ? (SLOT_W'(in_moved_piece) * SLOT_W'(SQUARES) +
                              SLOT_W'(in_to_square)) : '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign clr_last  = (clr_cnt_r == SLOT_W'(TABLE_DEPTH - 1));
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (clr_last) state_nxt = clr_emit_r ? ST_EMIT : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) state_nxt = (op_t'(in_opcode) == OP_CLEAR) ? ST_SWEEP : ST_MUL1;
      end
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_BONUS;
      ST_BONUS: state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_WB;
      ST_WB:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_addr  = slot_r;
    mem_wdata = sat;
    unique case (state_r)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE:  in_stall = 1'b0;
      ST_WB:    mem_we   = wb_upd;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      clr_cnt_r  <= '0;
      clr_emit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SWEEP) clr_cnt_r <= clr_last ? '0 : clr_cnt_r + 1'b1;
      if (in_accept) clr_emit_r <= (op_t'(in_opcode) == OP_CLEAR);
    end
  end

  // ---------------------------------------------------------------- score memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (in_accept) entry_r <= mem[in_slot];
  end

  // ---------------------------------------------------------------- shared multiplier
  always_comb begin
    case (state_r)
      ST_MUL1: begin
        mul_a = MUL_A_W'(depth_r);
        mul_b = MUL_B_W'(depth_r);
      end
      ST_MUL2: begin
        mul_a = MUL_A_W'(prod_r[CAP_W-1:0]);
        mul_b = MUL_B_W'(scale_r);
      end
      default: begin
        mul_a = MUL_A_W'(entry_r);
        mul_b = $signed({1'b0, bonus_r});
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------- gravity update
  // truncating divide by 32768: bias negative products before the shift
  assign rnd  = prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << GRAVITY_SHIFT) - 1) : '0);
  assign q    = rnd[GRAVITY_SHIFT+Q_W-1:GRAVITY_SHIFT];
  assign bsig = (op_r == OP_PENALIZE) ? -$signed(Q_W'(bonus_r)) : $signed(Q_W'(bonus_r));
  assign sum  = SUM_W'(entry_r) + SUM_W'(bsig) - SUM_W'(q);

  always_comb begin
    if (sum > SUM_W'(32768))       sat = SCORE_W'(32768);
    else if (sum < -SUM_W'(32768)) sat = -SCORE_W'(32768);
    else                           sat = sum[SCORE_W-1:0];
  end

  assign wb_skip  = (op_r == OP_PENALIZE) && (from_r == best_from_r) && (to_r == best_to_r);
  assign wb_upd   = ok_r && !wb_skip && ((op_r == OP_REWARD) || (op_r == OP_PENALIZE));
  assign wb_score = wb_upd ? sat : (ok_r ? entry_r : '0);

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= op_t'(in_opcode);
      from_r  <= in_from_square;
      to_r    <= in_to_square;
      depth_r <= in_depth;
      ok_r    <= in_ok;
      slot_r  <= in_slot;
    end
    prod_r <= prod;
    if (state_r == ST_BONUS) begin
      bonus_r <= (prod_r[23:0] < 24'(cap_r)) ? prod_r[CAP_W-1:0] : cap_r;
    end
    if (in_accept) begin
      pend_score_r <= '0;
      pend_skip_r  <= 1'b0;
    end else if (state_r == ST_WB) begin
      pend_score_r <= wb_score;
      pend_skip_r  <= wb_skip;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_score_r   <= pend_score_r;
      out_skipped_r <= pend_skip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_from_r <= '0;
      best_to_r   <= '0;
      cap_r       <= CAP_RESET;
      scale_r     <= SCALE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_WB && op_r == OP_REWARD) begin
        best_from_r <= from_r;
        best_to_r   <= to_r;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BONUS_CAP:   cap_r   <= cfg_data[CAP_W-1:0];
          REG_BONUS_SCALE: scale_r <= cfg_data[SCALE_W-1:0];
          default:         cap_r   <= cap_r;
        endcase
      end
      if (state_r == ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_score   = out_score_r;
  assign out_skipped = out_skipped_r;

endmodule

/* rtl/hgt_checker.sv */
module hgt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [hgt_pkg::SCORE_W-1:0] out_score,
  input logic                               out_skipped
);
  import hgt_pkg::*;

  // scores saturate to the gravity range
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_score <= SCORE_W'(32768)) && (out_score >= -SCORE_W'(32768)))
    else $error("score outside saturation range");

  // the sequencer is busy the cycle after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // reset leaves no word pending and runs the clearing sweep
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("output or input open straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_score) && $stable(out_skipped))
    else $error("stalled result word changed");

endmodule

bind history_gravity_table hgt_checker u_hgt_checker (.*);

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hgt_pkg::*;

  localparam int PROBES_A  = 15;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 75;
  localparam int LONG_HOLD = 300;

  typedef struct {
    op_t                op;
    logic [PIECE_W-1:0] piece;
    logic [SQ_W-1:0]    from_sq;
    logic [SQ_W-1:0]    to_sq;
    logic [DEPTH_W-1:0] depth;
  } move_t;

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic                      skipped;
  } outcome_t;

  // directed word plus, where typed is set, the result read straight off the rule
  typedef struct {
    op_t                       op;
    logic [PIECE_W-1:0]        piece;
    logic [SQ_W-1:0]           from_sq;
    logic [SQ_W-1:0]           to_sq;
    logic [DEPTH_W-1:0]        depth;
    bit                        typed;
    logic signed [SCORE_W-1:0] score;
    logic                      skipped;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       in_opcode;
  logic [PIECE_W-1:0]    in_moved_piece;
  logic [SQ_W-1:0]       in_from_square;
  logic [SQ_W-1:0]       in_to_square;
  logic [DEPTH_W-1:0]    in_depth;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [SCORE_W-1:0] out_score;
  logic                  out_skipped;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic signed [SCORE_W-1:0] hist_tab [TABLE_DEPTH];
  logic [SQ_W-1:0]           best_from_q;
  logic [SQ_W-1:0]           best_to_q;
  logic [CAP_W-1:0]          cap_r;
  logic [SCALE_W-1:0]        scale_r;

  outcome_t pending_scores [$];
  bit       failed    = 1'b0;
  bit       calm      = 1'b0;
  bit       hold_long = 1'b0;

  probe_t probes [21] = '{
    '{OP_READ,     4'd0,  6'd0,  6'd0,  8'd0,   1'b1, 17'sd0,      1'b0},
    '{OP_READ,     4'd11, 6'd63, 6'd63, 8'd255, 1'b1, 17'sd0,      1'b0},
    '{OP_REWARD,   4'd0,  6'd1,  6'd2,  8'd0,   1'b1, 17'sd0,      1'b0},
    '{OP_PENALIZE, 4'd0,  6'd1,  6'd2,  8'd0,   1'b1, 17'sd0,      1'b1},
    '{OP_REWARD,   4'd11, 6'd63, 6'd63, 8'd255, 1'b1, 17'sd1200,   1'b0},
    '{OP_PENALIZE, 4'd11, 6'd63, 6'd63, 8'd255, 1'b1, 17'sd1200,   1'b1},
    '{OP_PENALIZE, 4'd11, 6'd0,  6'd63, 8'd255, 1'b0, 17'sd0,      1'b0},
    '{OP_READ,     4'd11, 6'd0,  6'd63, 8'd0,   1'b0, 17'sd0,      1'b0},
    // piece out of range still moves the best-move squares
    '{OP_REWARD,   4'd12, 6'd5,  6'd6,  8'd3,   1'b1, 17'sd0,      1'b0},
    '{OP_PENALIZE, 4'd15, 6'd5,  6'd6,  8'd3,   1'b1, 17'sd0,      1'b1},
    '{OP_PENALIZE, 4'd3,  6'd7,  6'd6,  8'd5,   1'b0, 17'sd0,      1'b0},
    '{OP_PENALIZE, 4'd3,  6'd5,  6'd7,  8'd5,   1'b0, 17'sd0,      1'b0},
    '{OP_READ,     4'd14, 6'd0,  6'd0,  8'd0,   1'b1, 17'sd0,      1'b0},
    '{OP_CLEAR,    4'd0,  6'd0,  6'd0,  8'd0,   1'b1, 17'sd0,      1'b0},
    '{OP_READ,     4'd3,  6'd0,  6'd6,  8'd0,   1'b1, 17'sd0,      1'b0},
    // full cap and scale: bonus beyond the entry range, saturation both ways
    '{OP_REWARD,   4'd1,  6'd9,  6'd1,  8'd255, 1'b1, 17'sd32768,  1'b0},
    '{OP_REWARD,   4'd1,  6'd9,  6'd1,  8'd255, 1'b1, 17'sd32768,  1'b0},
    '{OP_PENALIZE, 4'd1,  6'd10, 6'd1,  8'd255, 1'b1, -17'sd32768, 1'b0},
    '{OP_PENALIZE, 4'd1,  6'd9,  6'd1,  8'd255, 1'b1, -17'sd32768, 1'b1},
    '{OP_READ,     4'd1,  6'd0,  6'd1,  8'd0,   1'b1, -17'sd32768, 1'b0},
    '{OP_REWARD,   4'd2,  6'd0,  6'd0,  8'd1,   1'b0, 17'sd0,      1'b0}
  };

  history_gravity_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_moved_piece (in_moved_piece),
    .in_from_square (in_from_square),
    .in_to_square   (in_to_square),
    .in_depth       (in_depth),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_score      (out_score),
    .out_skipped    (out_skipped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic signed [SCORE_W-1:0] pull_toward(
    input logic signed [SCORE_W-1:0] entry, input longint b);
    longint mag;
    longint nxt;
    mag = (b < 0) ? -b : b;
    // signed longint division truncates toward zero
    nxt = longint'(entry) + b - (longint'(entry) * mag) / 32768;
    if (nxt > 32768) nxt = 32768;
    if (nxt < -32768) nxt = -32768;
    return nxt[SCORE_W-1:0];
  endfunction

  function automatic outcome_t apply_move(input move_t m);
    outcome_t r;
    longint   d;
    longint   raw;
    longint   bonus;
    int       slot;
    bit       hit;
    d     = longint'(m.depth);
    raw   = longint'(scale_r) * d * d;
    bonus = (raw < longint'(cap_r)) ? raw : longint'(cap_r);
    hit   = (m.piece < PIECE_KINDS);
    slot  = int'(m.piece) * SQUARES + int'(m.to_sq);
    r.score   = '0;
    r.skipped = 1'b0;
    case (m.op)
      OP_REWARD: begin
        best_from_q = m.from_sq;
        best_to_q   = m.to_sq;
        if (hit) begin
          hist_tab[slot] = pull_toward(hist_tab[slot], bonus);
          r.score = hist_tab[slot];
        end
      end
      OP_PENALIZE: begin
        if (m.from_sq == best_from_q && m.to_sq == best_to_q) begin
          r.skipped = 1'b1;
          if (hit) r.score = hist_tab[slot];
        end else if (hit) begin
          hist_tab[slot] = pull_toward(hist_tab[slot], -bonus);
          r.score = hist_tab[slot];
        end
      end
      OP_READ: begin
        if (hit) r.score = hist_tab[slot];
      end
      default: begin
        foreach (hist_tab[i]) hist_tab[i] = '0;
      end
    endcase
    return r;
  endfunction

  // mostly hot entries so the gravity rule compounds, plus the stored best move
  function automatic move_t random_move();
    move_t m;
    int    k;
    k = $urandom_range(0, 99);
    if (k < 40)      m.op = OP_REWARD;
    else if (k < 75) m.op = OP_PENALIZE;
    else if (k < 97) m.op = OP_READ;
    else             m.op = OP_CLEAR;
    k = $urandom_range(0, 9);
    if (k < 7)       m.piece = PIECE_W'($urandom_range(0, 2));
    else if (k < 9)  m.piece = PIECE_W'($urandom_range(0, 11));
    else             m.piece = PIECE_W'($urandom_range(12, 15));
    m.from_sq = SQ_W'($urandom_range(0, 63));
    m.to_sq   = SQ_W'(($urandom_range(0, 9) < 6) ? $urandom_range(60, 63) :
                                                   $urandom_range(0, 63));
    m.depth   = DEPTH_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) :
                                                       $urandom_range(0, 255));
    if (m.op == OP_PENALIZE && $urandom_range(0, 2) == 0) begin
      m.from_sq = best_from_q;
      m.to_sq   = best_to_q;
    end
    return m;
  endfunction

  task automatic offer_move(input move_t m, input bit typed, input outcome_t want);
    outcome_t pred;
    in_valid       <= 1'b1;
    in_opcode      <= m.op;
    in_moved_piece <= m.piece;
    in_from_square <= m.from_sq;
    in_to_square   <= m.to_sq;
    in_depth       <= m.depth;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = apply_move(m);
    pending_scores.push_back(typed ? want : pred);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_BONUS_CAP) cap_r = val;
    else scale_r = val[SCALE_W-1:0];
  endtask

  task automatic set_bonus(input logic [CAP_W-1:0] cap, input logic [SCALE_W-1:0] scale);
    write_reg(REG_BONUS_CAP, cap);
    write_reg(REG_BONUS_SCALE, {{(CFG_DATA_W-SCALE_W){1'b0}}, scale});
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    move_t              m;
    outcome_t           want;
    logic [CAP_W-1:0]   cap;
    logic [SCALE_W-1:0] scale;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_READ;
    in_moved_piece <= '0;
    in_from_square <= '0;
    in_to_square   <= '0;
    in_depth       <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_BONUS_CAP;
    cfg_data       <= '0;
    foreach (hist_tab[i]) hist_tab[i] = '0;
    best_from_q = '0;
    best_to_q   = '0;
    cap_r       = CAP_RESET;
    scale_r     = SCALE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[i]) begin
      if (i == PROBES_A) begin
        settle();
        set_bonus('1, '1);
      end
      m    = '{probes[i].op, probes[i].piece, probes[i].from_sq, probes[i].to_sq,
               probes[i].depth};
      want = '{probes[i].score, probes[i].skipped};
      offer_move(m, probes[i].typed, want);
    end

    want = '{'0, 1'b0};
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cap = CAP_RESET; scale = SCALE_RESET; end
        1: begin cap = '0; scale = '0; end
        3: begin cap = '1; scale = '1; end
        2, 4: begin
          cap   = CAP_W'($urandom_range(0, 65535));
          scale = SCALE_W'($urandom_range(0, 255));
        end
        default: begin
          cap   = CAP_W'($urandom_range(0, 4000));
          scale = SCALE_W'($urandom_range(1, 64));
        end
      endcase
      settle();
      set_bonus(cap, scale);
      calm = (p == PHASES - 1);
      for (int k = 0; k < PHASE_LEN; k++) begin
        // receiver backs off for a long stretch while words keep coming
        if (p == 2 && k == 10) hold_long = 1'b1;
        offer_move(random_move(), 1'b0, want);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (failed) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end

  initial begin : rx_pacing
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_scores.size() == 0) begin
        $error("result word with nothing pending: score %0d skipped %0b",
               out_score, out_skipped);
        failed = 1'b1;
      end else begin
        exp_r = pending_scores.pop_front();
        if (out_score !== exp_r.score) begin
          $error("score: expected %0d, got %0d", exp_r.score, out_score);
          failed = 1'b1;
        end
        if (out_skipped !== exp_r.skipped) begin
          $error("skipped: expected %0b, got %0b", exp_r.skipped, out_skipped);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
